### hw/rtl/integer_decimal_field_formatter_macros.svh
// ----------------------------------------------------------------------------
// integer_decimal_field_formatter_macros
// Assertion macros for the decimal field formatter, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_DECIMAL_FIELD_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// property that holds on every rising clock edge out of reset
`define IDFF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// implication property, antecedent and consequent given as full sequences
`define IDFF_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define IDFF_ASSERT_ALWAYS(lbl, expr, msg)
`define IDFF_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/idff_pkg.sv
// ----------------------------------------------------------------------------
// idff_pkg
// Types, constants and the control store of the decimal field formatter.
// ----------------------------------------------------------------------------
package idff_pkg;

	localparam int VALUE_W     = 64;
	localparam int BCD_DIGITS  = 20;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int CHUNK_BITS  = 8;
	localparam int CONV_CHUNKS = VALUE_W / CHUNK_BITS;
	localparam int CHUNK_W     = $clog2(CONV_CHUNKS + 1);
	localparam int DIG_IDX_W   = $clog2(BCD_DIGITS);
	localparam int ND_W        = $clog2(BCD_DIGITS + 1);
	localparam int CNT_W       = 7;
	localparam int PC_W        = 3;

	// ascii codes
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_PLUS  = 8'h2b;
	localparam logic [7:0] CHR_MINUS = 8'h2d;
	localparam logic [7:0] CHR_ZERO  = 8'h30;

	// micro operations
	localparam logic [1:0] OP_CONV  = 2'd0;
	localparam logic [1:0] OP_SIZE1 = 2'd1;
	localparam logic [1:0] OP_SIZE2 = 2'd2;
	localparam logic [1:0] OP_EMIT  = 2'd3;

	// character source of an emit step
	localparam logic [1:0] CH_SPACE = 2'd0;
	localparam logic [1:0] CH_SIGN  = 2'd1;
	localparam logic [1:0] CH_ZERO  = 2'd2;
	localparam logic [1:0] CH_DIGIT = 2'd3;

	// run length loaded when a segment finishes
	localparam logic [2:0] LD_NONE  = 3'd0;
	localparam logic [2:0] LD_SIGN  = 3'd1;
	localparam logic [2:0] LD_ZERO  = 3'd2;
	localparam logic [2:0] LD_DIG   = 3'd3;
	localparam logic [2:0] LD_TRAIL = 3'd4;

	// step addresses
	localparam logic [PC_W-1:0] STEP_CONV  = 3'd0;
	localparam logic [PC_W-1:0] STEP_SIZE1 = 3'd1;
	localparam logic [PC_W-1:0] STEP_SIZE2 = 3'd2;
	localparam logic [PC_W-1:0] STEP_LEAD  = 3'd3;
	localparam logic [PC_W-1:0] STEP_SIGN  = 3'd4;
	localparam logic [PC_W-1:0] STEP_ZERO  = 3'd5;
	localparam logic [PC_W-1:0] STEP_DIG   = 3'd6;
	localparam logic [PC_W-1:0] STEP_TRAIL = 3'd7;

	typedef struct packed {
		logic [1:0]      op;
		logic [1:0]      chr;
		logic [2:0]      ld;
		logic [PC_W-1:0] nxt;
		logic            fin;
	} ctl_word_t;

	// control store: one word per step
	function automatic ctl_word_t ctl_rom(input logic [PC_W-1:0] pc);
		ctl_word_t w;
		unique case (pc)
			STEP_CONV:  w = '{OP_CONV,  CH_SPACE, LD_NONE,  STEP_SIZE1, 1'b0};
			STEP_SIZE1: w = '{OP_SIZE1, CH_SPACE, LD_NONE,  STEP_SIZE2, 1'b0};
			STEP_SIZE2: w = '{OP_SIZE2, CH_SPACE, LD_NONE,  STEP_LEAD,  1'b0};
			STEP_LEAD:  w = '{OP_EMIT,  CH_SPACE, LD_SIGN,  STEP_SIGN,  1'b0};
			STEP_SIGN:  w = '{OP_EMIT,  CH_SIGN,  LD_ZERO,  STEP_ZERO,  1'b0};
			STEP_ZERO:  w = '{OP_EMIT,  CH_ZERO,  LD_DIG,   STEP_DIG,   1'b0};
			STEP_DIG:   w = '{OP_EMIT,  CH_DIGIT, LD_TRAIL, STEP_TRAIL, 1'b0};
			STEP_TRAIL: w = '{OP_EMIT,  CH_SPACE, LD_NONE,  STEP_CONV,  1'b1};
			default:    w = '{OP_CONV,  CH_SPACE, LD_NONE,  STEP_CONV,  1'b1};
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/integer_decimal_field_formatter.sv
// The request is converted from binary to decimal a chunk of bits at a time,
// then sized; the characters follow in order, one per cycle while the output
// does not stall, with an idle step for each empty segment ahead of a character.
// A new request is accepted only after the sequencer has emitted the last
// character of the previous field.
// Reset: arst_n clears the sequencer and the output valid flag at once.
// ----------------------------------------------------------------------------
// integer_decimal_field_formatter
// Formats a 64-bit integer as a padded decimal field, one field per
// request, using a microcoded sequencer over a shift-add-3 converter.
// ----------------------------------------------------------------------------
`include "integer_decimal_field_formatter_macros.svh"

module integer_decimal_field_formatter #(
	parameter int MAX_FIELD = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [idff_pkg::VALUE_W-1:0] value_bits,
	input  logic                         is_unsigned,
	input  logic                         left_justify,
	input  logic                         force_plus,
	input  logic                         space_sign,
	input  logic                         zero_pad,
	input  logic [5:0]                   field_width,
	input  logic signed [6:0]            digit_precision,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_char,
	output logic                         last,
	output logic [idff_pkg::CNT_W-1:0]   char_count
);

	import idff_pkg::*;

	// request registers
	logic                  busy_q;
	logic [PC_W-1:0]       pc_q;
	logic [CHUNK_W-1:0]    chunk_q;
	logic [VALUE_W-1:0]    mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  left_q;
	logic                  zflag_q;
	logic                  sign_en_q;
	logic [7:0]            sign_chr_q;
	logic [5:0]            width_q;
	logic [5:0]            prec_q;
	logic                  prec_none_q;
	logic [ND_W-1:0]       nd_q;
	logic [CNT_W-1:0]      zeros_q;
	logic [CNT_W-1:0]      pad_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      e_q;
	logic [CNT_W-1:0]      run_q;

	// output register
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  last_q;
	logic [CNT_W-1:0]      count_q;

	ctl_word_t             cw;
	logic                  in_fire;
	logic                  can_emit;
	logic                  emit_fire;
	logic                  neg;
	logic [5:0]            width_c;
	logic [5:0]            prec_c;
	logic [BCD_W-1:0]      bcd_nx;
	logic [ND_W-1:0]       top_dig;
	logic [ND_W-1:0]       nd_nx;
	logic [CNT_W-1:0]      zeros_nx;
	logic [CNT_W-1:0]      body;
	logic [CNT_W-1:0]      pad_nx;
	logic                  zfill;
	logic [CNT_W-1:0]      ld_cnt;
	logic [CNT_W-1:0]      run_dec;
	logic [DIG_IDX_W-1:0]  dig_idx;
	logic [7:0]            emit_chr;
	logic [CNT_W-1:0]      e_inc;

	assign cw       = ctl_rom(pc_q);
	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign can_emit = !out_valid_q || out_ready;
	assign emit_fire = busy_q && (cw.op == OP_EMIT) && (run_q != '0) && can_emit;

	// argument decode at request time
	assign neg     = !is_unsigned && value_bits[VALUE_W-1];
	assign width_c = (int'(field_width) > MAX_FIELD) ? 6'(MAX_FIELD) : field_width;
	assign prec_c  = (int'(digit_precision[5:0]) > MAX_FIELD) ? 6'(MAX_FIELD)
	                                                          : digit_precision[5:0];

	// one chunk of shift-add-3 conversion, most significant bits first
	always_comb begin
		bcd_nx = bcd_q;
		for (int k = 0; k < CHUNK_BITS; k++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (bcd_nx[d*4 +: 4] > 4'd4)
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], mag_q[VALUE_W-1-k]};
		end
	end

	// digit count and precision zeros
	always_comb begin
		top_dig = '0;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0)
				top_dig = ND_W'(d + 1);
		end
		if (top_dig != '0)
			nd_nx = top_dig;
		else if (!prec_none_q && prec_q == 6'd0)
			nd_nx = '0;
		else
			nd_nx = ND_W'(1);
		if (!prec_none_q && {1'b0, prec_q} > CNT_W'(nd_nx))
			zeros_nx = {1'b0, prec_q} - CNT_W'(nd_nx);
		else
			zeros_nx = '0;
	end

	// body length and padding
	always_comb begin
		body   = CNT_W'(sign_en_q) + zeros_q + CNT_W'(nd_q);
		pad_nx = ({1'b0, width_q} > body) ? ({1'b0, width_q} - body) : '0;
		zfill  = zflag_q && prec_none_q && !left_q;
	end

	// length of the segment that follows
	always_comb begin
		case (cw.ld)
			LD_SIGN:  ld_cnt = CNT_W'(sign_en_q);
			LD_ZERO:  ld_cnt = zeros_q;
			LD_DIG:   ld_cnt = CNT_W'(nd_q);
			LD_TRAIL: ld_cnt = left_q ? pad_q : '0;
			default:  ld_cnt = '0;
		endcase
	end

	// character of the current emit step
	assign run_dec = run_q - CNT_W'(1);
	assign dig_idx = run_dec[DIG_IDX_W-1:0];
	always_comb begin
		case (cw.chr)
			CH_SIGN:  emit_chr = sign_chr_q;
			CH_ZERO:  emit_chr = CHR_ZERO;
			CH_DIGIT: emit_chr = CHR_ZERO | {4'd0, bcd_q[dig_idx*4 +: 4]};
			default:  emit_chr = CHR_SPACE;
		endcase
	end
	assign e_inc = e_q + CNT_W'(1);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pc_q    <= STEP_CONV;
			chunk_q <= '0;
			run_q   <= '0;
			e_q     <= '0;
			n_q     <= '0;
		end else if (in_fire) begin
			busy_q  <= 1'b1;
			pc_q    <= STEP_CONV;
			chunk_q <= CHUNK_W'(CONV_CHUNKS);
			run_q   <= '0;
			e_q     <= '0;
		end else if (busy_q) begin
			unique case (cw.op)
				OP_CONV: begin
					chunk_q <= chunk_q - CHUNK_W'(1);
					if (chunk_q == CHUNK_W'(1))
						pc_q <= cw.nxt;
				end
				OP_SIZE1: begin
					pc_q <= cw.nxt;
				end
				OP_SIZE2: begin
					n_q   <= body + pad_nx;
					run_q <= (left_q || zfill) ? '0 : pad_nx;
					pc_q  <= cw.nxt;
				end
				OP_EMIT: begin
					if (run_q == '0 || (emit_fire && run_q == CNT_W'(1))) begin
						run_q <= ld_cnt;
						pc_q  <= cw.nxt;
						if (cw.fin)
							busy_q <= 1'b0;
					end else if (emit_fire) begin
						run_q <= run_dec;
					end
					if (emit_fire)
						e_q <= e_inc;
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// payload registers of the request in flight
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_q       <= neg ? (VALUE_W'(0) - value_bits) : value_bits;
			bcd_q       <= '0;
			left_q      <= left_justify;
			zflag_q     <= zero_pad;
			width_q     <= width_c;
			prec_q      <= prec_c;
			prec_none_q <= digit_precision[6];
			sign_en_q   <= neg || (!is_unsigned && (force_plus || space_sign));
			sign_chr_q  <= neg ? CHR_MINUS : (force_plus ? CHR_PLUS : CHR_SPACE);
		end else if (busy_q) begin
			if (cw.op == OP_CONV) begin
				bcd_q <= bcd_nx;
				mag_q <= {mag_q[VALUE_W-CHUNK_BITS-1:0], CHUNK_BITS'(0)};
			end
			if (cw.op == OP_SIZE1) begin
				nd_q    <= nd_nx;
				zeros_q <= zeros_nx;
			end
			if (cw.op == OP_SIZE2) begin
				zeros_q <= zfill ? (zeros_q + pad_nx) : zeros_q;
				pad_q   <= zfill ? '0 : pad_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_char_q <= emit_chr;
			last_q     <= (e_inc == n_q);
			count_q    <= (e_inc == n_q) ? n_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign last       = last_q;
	assign char_count = count_q;

	// checks
	`IDFF_ASSERT_IMPLY(a_start, in_fire, ##1 (busy_q && pc_q == STEP_CONV), "request not started")
	`IDFF_ASSERT_ALWAYS(a_count_bound, (!busy_q || e_q <= n_q), "emitted past field length")
	`IDFF_ASSERT_IMPLY(a_done_count, $fell(busy_q), e_q == n_q, "field ended short")
	`IDFF_ASSERT_IMPLY(a_last_count, (out_valid && last), char_count != '0, "last without count")
	`IDFF_ASSERT_IMPLY(a_mid_count, (out_valid && !last), char_count == '0, "count before last")

endmodule

### tb/tb_integer_decimal_field_formatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_decimal_field_formatter
// Drives decimal conversion requests with random flags, widths and precisions
// through the valid/ready input, predicts every character of each padded
// field and checks the character stream in order, under random stalls and
// one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_integer_decimal_field_formatter;
	import idff_pkg::*;

	localparam int MAX_FIELD      = 63;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_STRETCH   = 300;
	localparam int PREC_NONE      = -1;

	typedef struct {
		logic [63:0]       value;
		bit                uns;
		bit                left;
		bit                plus;
		bit                space;
		bit                zero;
		logic [5:0]        width;
		logic signed [6:0] prec;
	} field_req_t;

	typedef struct {
		logic [7:0]       ch;
		logic             last;
		logic [CNT_W-1:0] count;
	} char_res_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [VALUE_W-1:0]      value_bits;
	logic                    is_unsigned;
	logic                    left_justify;
	logic                    force_plus;
	logic                    space_sign;
	logic                    zero_pad;
	logic [5:0]              field_width;
	logic signed [6:0]       digit_precision;
	logic                    out_valid;
	logic                    out_ready;
	logic [7:0]              out_char;
	logic                    last;
	logic [CNT_W-1:0]        char_count;

	char_res_t expected_chars[$];
	int        error_count;
	int        stalled_cycles;
	int        hold_cycles;
	bit        no_idle;

	integer_decimal_field_formatter #(
		.MAX_FIELD(MAX_FIELD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value_bits(value_bits),
		.is_unsigned(is_unsigned),
		.left_justify(left_justify),
		.force_plus(force_plus),
		.space_sign(space_sign),
		.zero_pad(zero_pad),
		.field_width(field_width),
		.digit_precision(digit_precision),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.last(last),
		.char_count(char_count)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic field_req_t fmt_req(input logic [63:0] value, input bit uns,
			input bit left, input bit plus, input bit space, input bit zero,
			input int width, input int prec);
		field_req_t r;
		r.value = value;
		r.uns   = uns;
		r.left  = left;
		r.plus  = plus;
		r.space = space;
		r.zero  = zero;
		r.width = 6'(width);
		r.prec  = 7'(prec);
		return r;
	endfunction

	// expected characters of one field: spaces, sign, zeros, digits, spaces
	function automatic void format_field(input field_req_t r);
		logic [63:0] mag;
		logic [7:0]  digits[$];
		logic [7:0]  sign_ch;
		char_res_t   c;
		char_res_t   field[$];
		bit          neg;
		bit          has_sign;
		bit          zfill;
		int          width;
		int          prec;
		int          zeros;
		int          body;
		int          pad;

		prec  = r.prec[6] ? PREC_NONE : int'(r.prec);
		width = int'(r.width);
		if (width > MAX_FIELD)
			width = MAX_FIELD;
		if (prec > MAX_FIELD)
			prec = MAX_FIELD;

		neg = !r.uns && r.value[63];
		mag = neg ? 64'd0 - r.value : r.value;

		// sign selection, plus wins over space
		has_sign = 1'b1;
		if (neg)
			sign_ch = CHR_MINUS;
		else if (!r.uns && r.plus)
			sign_ch = CHR_PLUS;
		else if (!r.uns && r.space)
			sign_ch = CHR_SPACE;
		else
			has_sign = 1'b0;

		// zero value with zero precision prints no digits
		if (!(mag == 64'd0 && prec == 0)) begin
			do begin
				digits.push_front(CHR_ZERO + 8'(mag % 64'd10));
				mag = mag / 64'd10;
			end while (mag != 64'd0);
		end

		zeros = (prec > digits.size()) ? prec - digits.size() : 0;
		body  = int'(has_sign) + zeros + digits.size();
		pad   = (width > body) ? width - body : 0;
		zfill = r.zero && prec < 0 && !r.left;
		if (zfill) begin
			zeros += pad;
			pad = 0;
		end

		c.last  = 1'b0;
		c.count = '0;
		c.ch    = CHR_SPACE;
		if (!r.left)
			repeat (pad) field.push_back(c);
		if (has_sign) begin
			c.ch = sign_ch;
			field.push_back(c);
		end
		c.ch = CHR_ZERO;
		repeat (zeros) field.push_back(c);
		foreach (digits[i]) begin
			c.ch = digits[i];
			field.push_back(c);
		end
		c.ch = CHR_SPACE;
		if (r.left)
			repeat (pad) field.push_back(c);

		if (field.size() > 0) begin
			field[field.size() - 1].last  = 1'b1;
			field[field.size() - 1].count = CNT_W'(field.size());
		end
		foreach (field[i])
			expected_chars.push_back(field[i]);
	endfunction

	// one request: optional gap, hold valid until accepted, then predict
	task automatic send_field(input field_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        = 1'b1;
		value_bits      = r.value;
		is_unsigned     = r.uns;
		left_justify    = r.left;
		force_plus      = r.plus;
		space_sign      = r.space;
		zero_pad        = r.zero;
		field_width     = r.width;
		digit_precision = r.prec;
		do
			@(posedge clk);
		while (!in_ready);
		format_field(r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// random request biased toward short fields and interesting values
	function automatic field_req_t random_field();
		field_req_t  r;
		logic [63:0] p10;
		int          k;

		case ($urandom_range(0, 5))
			0: r.value = 64'($urandom_range(0, 999));
			1: r.value = {$urandom, $urandom};
			2: r.value = 64'd0 - 64'($urandom_range(1, 99999));
			3: begin
				case ($urandom_range(0, 4))
					0: r.value = 64'd0;
					1: r.value = '1;
					2: r.value = {1'b1, 63'd0};
					3: r.value = {1'b0, {63{1'b1}}};
					default: r.value = 64'd1;
				endcase
			end
			4: begin
				// around a power of ten
				p10 = 64'd1;
				k = $urandom_range(0, 19);
				repeat (k) p10 = p10 * 64'd10;
				r.value = p10 + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase

		r.uns   = $urandom_range(0, 2) == 0;
		r.left  = $urandom_range(0, 3) == 0;
		r.plus  = $urandom_range(0, 2) == 0;
		r.space = $urandom_range(0, 2) == 0;
		r.zero  = $urandom_range(0, 2) == 0;
		r.width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 16));

		k = $urandom_range(0, 9);
		if (k < 3)
			r.prec = 7'(PREC_NONE);
		else if (k == 3)
			r.prec = 7'($urandom_range(64, 127));
		else if (k == 4)
			r.prec = 7'($urandom_range(0, 63));
		else
			r.prec = 7'($urandom_range(0, 12));
		return r;
	endfunction

	// receiver: random stalls, or one long hold when a test asks for it
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				n = hold_cycles;
				hold_cycles = 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				n = pick_gap();
				if (n == 0) begin
					out_ready = 1'b1;
				end else begin
					out_ready = 1'b0;
					repeat (n - 1) @(negedge clk);
				end
			end
		end
	end

	// compare each character with the oldest prediction
	always @(posedge clk) begin : char_check
		char_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				error_count++;
				$display("%0t: unexpected character expected none got %h", $time, out_char);
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch) begin
					error_count++;
					$display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
				end
				if (last !== want.last) begin
					error_count++;
					$display("%0t: last expected %b got %b", $time, want.last, last);
				end
				if (char_count !== want.count) begin
					error_count++;
					$display("%0t: char_count expected %0d got %0d", $time, want.count,
						char_count);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// signs, plus over space, unsigned ignores sign flags
	task automatic test_signs();
		send_field(fmt_req(64'd42, 0, 0, 0, 0, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd0 - 64'd42, 0, 0, 0, 0, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd42, 0, 0, 1, 0, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd42, 0, 0, 0, 1, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd7, 0, 0, 1, 1, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd7, 1, 0, 1, 1, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd0 - 64'd5, 0, 0, 1, 1, 0, 0, PREC_NONE));
	endtask

	// zero padding rules, zero value with zero precision, other negative precisions
	task automatic test_padding();
		send_field(fmt_req(64'd0 - 64'd123, 0, 0, 0, 0, 1, 8, PREC_NONE));
		send_field(fmt_req(64'd123, 0, 0, 0, 0, 1, 8, 2));
		send_field(fmt_req(64'd5, 0, 1, 1, 0, 1, 8, PREC_NONE));
		send_field(fmt_req(64'd0 - 64'd3, 0, 0, 0, 0, 0, 10, 6));
		send_field(fmt_req(64'd0, 0, 0, 0, 0, 0, 0, 0));
		send_field(fmt_req(64'd0, 0, 0, 0, 0, 0, 4, 0));
		send_field(fmt_req(64'd0, 0, 0, 1, 0, 0, 0, 0));
		send_field(fmt_req(64'd0, 0, 0, 0, 0, 1, 5, -64));
		send_field(fmt_req(64'd9, 0, 0, 0, 0, 1, 4, -38));
	endtask

	// value extremes and the longest fields
	task automatic test_extremes();
		send_field(fmt_req('1, 1, 0, 0, 0, 0, 0, PREC_NONE));
		send_field(fmt_req('1, 0, 0, 0, 0, 0, 0, PREC_NONE));
		send_field(fmt_req({1'b1, 63'd0}, 0, 0, 0, 0, 1, 25, PREC_NONE));
		send_field(fmt_req({1'b0, {63{1'b1}}}, 0, 0, 1, 0, 0, 0, PREC_NONE));
		send_field(fmt_req({1'b1, 63'd0}, 1, 0, 0, 0, 0, 0, PREC_NONE));
		send_field(fmt_req(64'd1, 0, 1, 0, 0, 0, 63, 63));
		send_field(fmt_req(64'd0 - 64'd1, 0, 0, 0, 0, 0, 63, 63));
		send_field(fmt_req(64'd0, 0, 0, 0, 1, 0, 63, 0));
	endtask

	task automatic test_random_fields(input int count);
		repeat (count) send_field(random_field());
	endtask

	// no idling on either side
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		repeat (count) send_field(random_field());
		no_idle = 1'b0;
	endtask

	// long receiver hold while requests keep coming
	task automatic test_output_hold(input int count);
		field_req_t r;
		hold_cycles = HOLD_STRETCH;
		repeat (count) begin
			r = random_field();
			r.width = 6'($urandom_range(16, 40));
			send_field(r);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		value_bits      = '0;
		is_unsigned     = 1'b0;
		left_justify    = 1'b0;
		force_plus      = 1'b0;
		space_sign      = 1'b0;
		zero_pad        = 1'b0;
		field_width     = '0;
		digit_precision = '0;
		error_count     = 0;
		stalled_cycles  = 0;
		hold_cycles     = 0;
		no_idle         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_signs();
		test_padding();
		test_extremes();
		test_random_fields(110);
		test_output_hold(12);
		test_back_to_back(20);
		test_random_fields(90);

		// drain outstanding characters, then allow for a trailing empty field
		in_valid = 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
